// ----- rtl/core/rabs_pkg.sv -----
// Package for the running-average background subtraction block.
// Holds constants, the register index codes and the per-item tag type.
// No dependencies; used by rabs_front, rabs_back and the top level.
`default_nettype none

package rabs_pkg;

   // Store size and front/back queue depth
   localparam int MAX_PIXELS  = 524288;
   localparam int QUEUE_DEPTH = 4;

   // Gray weights in units of 1/1000
   localparam int GRAY_WB = 114;
   localparam int GRAY_WG = 587;
   localparam int GRAY_WR = 299;

   // Weighted sum of a pixel is at most 1000 * 255, which fits in 18 bits
   localparam int SUM_W = 18;

   // floor(sum / 1000) == (sum * GRAY_RECIP) >> RECIP_SHIFT for every sum < 2^18
   localparam int RECIP_W     = 19;
   localparam int RECIP_SHIFT = 28;
   localparam logic [RECIP_W-1:0] GRAY_RECIP = 19'd268436;
   localparam int PROD_W = SUM_W + RECIP_W;

   // Register widths and reset values
   localparam int ALPHA_W = 9;
   localparam int THRESH_W = 8;
   localparam int CSR_DATA_W = 9;
   localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 9'd179;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd25;
   localparam logic [ALPHA_W-1:0]  ALPHA_ONE    = 9'd256;

   // Mask values
   localparam logic [7:0] MASK_FG = 8'hFF;
   localparam logic [7:0] MASK_BG = 8'h00;

   // Register index codes
   typedef enum logic [0:0] {
      CSR_ALPHA_Q8        = 1'b0,
      CSR_NOISE_THRESHOLD = 1'b1
   } rabs_csr_type;

   // Per-request control carried from front to back
   typedef struct packed {
      logic first_frame;  // store seed only, no result
      logic frame_end;    // last pixel of the frame
   } rabs_tag_type;

endpackage

`default_nettype wire

// ----- rtl/core/rabs_front.sv -----
// Front end: accepts pixel requests, converts them to gray, assigns store addresses.
// Two register stages feed the request queue. Depends on rabs_pkg.
`default_nettype none

module rabs_front #(
   parameter int MAX_PIXELS = rabs_pkg::MAX_PIXELS,
   parameter int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request side
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_blue,
   input  wire logic [7:0]             req_green,
   input  wire logic [7:0]             req_red,
   input  wire logic                   req_frame_end,
   // queue side
   input  wire logic                   q_full,
   output logic                        q_push,
   output logic [7:0]                  q_gray,
   output logic [AW-1:0]               q_addr,
   output rabs_pkg::rabs_tag_type      q_tag
);

   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PIXELS - 1);

   logic front_adv;
   logic accept;

   logic [AW-1:0]               addr_ff, addr_in;
   logic                        ready_ff, ready_in;

   logic                        f1_v_ff;
   logic [rabs_pkg::SUM_W-1:0]  f1_sum_ff, f1_sum_in;
   logic [AW-1:0]               f1_addr_ff;
   rabs_pkg::rabs_tag_type      f1_tag_ff, f1_tag_in;

   logic                        f2_v_ff;
   logic [7:0]                  f2_gray_ff, f2_gray_in;
   logic [AW-1:0]               f2_addr_ff;
   rabs_pkg::rabs_tag_type      f2_tag_ff;

   logic [rabs_pkg::PROD_W-1:0] prod;

   // Whole front moves together; it holds only when the queue cannot take stage 2
   assign front_adv = !(f2_v_ff && q_full);
   assign req_stall = !front_adv;
   assign accept    = req_valid && front_adv;

   // Weighted sum of the three components
   always_comb begin
      f1_sum_in = rabs_pkg::SUM_W'(rabs_pkg::GRAY_WB * int'(req_blue))
                + rabs_pkg::SUM_W'(rabs_pkg::GRAY_WG * int'(req_green))
                + rabs_pkg::SUM_W'(rabs_pkg::GRAY_WR * int'(req_red));
      f1_tag_in.first_frame = !ready_ff;
      f1_tag_in.frame_end   = req_frame_end;
   end

   // Divide by 1000 through the reciprocal
   always_comb begin
      prod = rabs_pkg::PROD_W'(f1_sum_ff) * rabs_pkg::PROD_W'(rabs_pkg::GRAY_RECIP);
      f2_gray_in = prod[rabs_pkg::RECIP_SHIFT +: 8];
   end

   // Pixel address and first-frame flag
   always_comb begin
      addr_in  = addr_ff;
      ready_in = ready_ff;
      if (accept) begin
         if (req_frame_end || addr_ff == LAST_ADDR) begin
            addr_in = '0;
         end else begin
            addr_in = addr_ff + AW'(1);
         end
         if (req_frame_end) begin
            ready_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff  <= '0;
         ready_ff <= 1'b0;
         f1_v_ff  <= 1'b0;
         f2_v_ff  <= 1'b0;
      end else begin
         addr_ff  <= addr_in;
         ready_ff <= ready_in;
         if (front_adv) begin
            f1_v_ff <= req_valid;
            f2_v_ff <= f1_v_ff;
         end
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (front_adv) begin
         f1_sum_ff  <= f1_sum_in;
         f1_addr_ff <= addr_ff;
         f1_tag_ff  <= f1_tag_in;
         f2_gray_ff <= f2_gray_in;
         f2_addr_ff <= f1_addr_ff;
         f2_tag_ff  <= f1_tag_ff;
      end
   end

   assign q_push = f2_v_ff && front_adv;
   assign q_gray = f2_gray_ff;
   assign q_addr = f2_addr_ff;
   assign q_tag  = f2_tag_ff;

endmodule

`default_nettype wire

// ----- rtl/core/rabs_queue.sv -----
// Short FIFO between the front and back ends.
// Carries packed requests; depends on no package contents.
`default_nettype none

module rabs_queue #(
   parameter int W = 8,
   parameter int DEPTH = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire logic [W-1:0]  push_data,
   output logic               full,
   input  wire logic          pop,
   output logic               empty,
   output logic [W-1:0]       head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [W-1:0]  slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/rabs_back.sv -----
// Back end: background store read-modify-write, running-average update,
// threshold compare and the result register. Depends on rabs_pkg.
`default_nettype none

module rabs_back #(
   parameter int MAX_PIXELS = rabs_pkg::MAX_PIXELS,
   parameter int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // queue side
   input  wire logic                          q_empty,
   input  wire logic [7:0]                    q_gray,
   input  wire logic [AW-1:0]                 q_addr,
   input  wire rabs_pkg::rabs_tag_type        q_tag,
   output logic                               q_pop,
   // settings
   input  wire logic [rabs_pkg::ALPHA_W-1:0]  alpha_q8,
   input  wire logic [rabs_pkg::THRESH_W-1:0] noise_threshold,
   // result side
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [7:0]                         rsp_foreground,
   output logic [7:0]                         rsp_background_level,
   output logic                               rsp_frame_last
);

   logic back_adv;

   // background store, Q8.8
   logic [15:0] store_mem [MAX_PIXELS];
   logic [15:0] rd_data_ff;

   // stage 1: read data arrives
   logic                   b1_v_ff;
   logic [7:0]             b1_gray_ff;
   logic [AW-1:0]          b1_addr_ff;
   rabs_pkg::rabs_tag_type b1_tag_ff;

   // stage 2: updated value, written to the store as it leaves
   logic                   b2_v_ff;
   logic [7:0]             b2_gray_ff;
   logic [AW-1:0]          b2_addr_ff;
   rabs_pkg::rabs_tag_type b2_tag_ff;
   logic [15:0]            b2_nb_ff, b2_nb_in;

   // write that landed on the same edge as the stage 1 read
   logic                   lw_v_ff;
   logic [AW-1:0]          lw_addr_ff;
   logic [15:0]            lw_data_ff;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_fg_ff, rsp_fg_in;
   logic [7:0]             rsp_level_ff, rsp_level_in;
   logic                   rsp_last_ff;

   logic [rabs_pkg::ALPHA_W-1:0] alpha_sat;
   logic [rabs_pkg::ALPHA_W-1:0] alpha_inv;
   logic [15:0] bg;
   logic [24:0] p_new, p_old;
   logic [25:0] mix_sum;
   logic [17:0] nb_full;
   logic [15:0] nb;
   logic [16:0] lvl_sum;
   logic [8:0]  lvl_wide;
   logic [7:0]  diff;

   // Whole back end advances unless a result is waiting and stalled
   assign back_adv = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = back_adv && !q_empty;

   // Stage 1: forward pending writes, then mix new gray into background
   always_comb begin
      if (b2_v_ff && b2_addr_ff == b1_addr_ff) begin
         bg = b2_nb_ff;
      end else if (lw_v_ff && lw_addr_ff == b1_addr_ff) begin
         bg = lw_data_ff;
      end else begin
         bg = rd_data_ff;
      end
      // alpha above one saturates to one
      if (alpha_q8 > rabs_pkg::ALPHA_ONE) begin
         alpha_sat = rabs_pkg::ALPHA_ONE;
      end else begin
         alpha_sat = alpha_q8;
      end
      alpha_inv = rabs_pkg::ALPHA_ONE - alpha_sat;
      p_new   = 25'(alpha_sat) * 25'({b1_gray_ff, 8'h00});
      p_old   = 25'(alpha_inv) * 25'(bg);
      mix_sum = 26'(p_new) + 26'(p_old) + 26'd128;
      nb_full = mix_sum[25:8];
      nb      = (nb_full[17:16] != 2'b00) ? 16'hFFFF : nb_full[15:0];
      // first frame seeds the store with gray in Q8.8
      b2_nb_in = b1_tag_ff.first_frame ? {b1_gray_ff, 8'h00} : nb;
   end

   // Stage 2: round to 8 bits and compare with gray
   always_comb begin
      lvl_sum      = 17'(b2_nb_ff) + 17'd128;
      lvl_wide     = lvl_sum[16:8];
      rsp_level_in = lvl_wide[8] ? 8'hFF : lvl_wide[7:0];
      if (b2_gray_ff > rsp_level_in) begin
         diff = b2_gray_ff - rsp_level_in;
      end else begin
         diff = rsp_level_in - b2_gray_ff;
      end
      rsp_fg_in    = (diff > noise_threshold) ? rabs_pkg::MASK_FG : rabs_pkg::MASK_BG;
      rsp_valid_in = b2_v_ff && !b2_tag_ff.first_frame;
   end

   // Store: read at queue head, write from stage 2 (read returns old data)
   always_ff @(posedge clock) begin
      if (back_adv) begin
         if (b2_v_ff) begin
            store_mem[b2_addr_ff] <= b2_nb_ff;
         end
         rd_data_ff <= store_mem[q_addr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff      <= 1'b0;
         b2_v_ff      <= 1'b0;
         lw_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (back_adv) begin
         b1_v_ff      <= q_pop;
         b2_v_ff      <= b1_v_ff;
         lw_v_ff      <= b2_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (back_adv) begin
         b1_gray_ff   <= q_gray;
         b1_addr_ff   <= q_addr;
         b1_tag_ff    <= q_tag;
         b2_gray_ff   <= b1_gray_ff;
         b2_addr_ff   <= b1_addr_ff;
         b2_tag_ff    <= b1_tag_ff;
         b2_nb_ff     <= b2_nb_in;
         lw_addr_ff   <= b2_addr_ff;
         lw_data_ff   <= b2_nb_ff;
         rsp_fg_ff    <= rsp_fg_in;
         rsp_level_ff <= rsp_level_in;
         rsp_last_ff  <= b2_tag_ff.frame_end;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_foreground       = rsp_fg_ff;
   assign rsp_background_level = rsp_level_ff;
   assign rsp_frame_last       = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/running_average_background_subtraction_top.sv -----
// Top level of the running-average background subtraction block.
// Holds the settings registers and joins front, queue and back; uses rabs_pkg.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    blue, green, red, frame_end
//   rsp      out        rsp_valid/stall    foreground, background_level, frame_last
//   csr      in         csr_write          csr_index, csr_wdata
//
// One pixel per clock sustained while rsp_stall is low; the background store
// is read and written once per pixel through one read and one write port, which
// sets that figure. Requests pass f1, f2, the queue, b1, b2, result register.
// Synchronous reset clears control state; the store is not cleared and is
// first written by the first frame. A stalled result holds the back end; the
// queue absorbs the front until it fills, then req_stall rises.
`default_nettype none

module running_average_background_subtraction_top #(
   parameter int MAX_PIXELS  = rabs_pkg::MAX_PIXELS,
   parameter int QUEUE_DEPTH = rabs_pkg::QUEUE_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // requests
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_blue,
   input  wire logic [7:0]                       req_green,
   input  wire logic [7:0]                       req_red,
   input  wire logic                             req_frame_end,
   // results
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [7:0]                            rsp_foreground,
   output logic [7:0]                            rsp_background_level,
   output logic                                  rsp_frame_last,
   // settings
   input  wire logic                             csr_write,
   input  wire logic [0:0]                       csr_index,
   input  wire logic [rabs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int TAG_W = $bits(rabs_pkg::rabs_tag_type);
   localparam int QW    = 8 + AW + TAG_W;

   logic [rabs_pkg::ALPHA_W-1:0]  alpha_ff, alpha_in;
   logic [rabs_pkg::THRESH_W-1:0] thresh_ff, thresh_in;

   logic                   q_push, q_full, q_pop, q_empty;
   logic [7:0]             f_gray;
   logic [AW-1:0]          f_addr;
   rabs_pkg::rabs_tag_type f_tag;
   logic [QW-1:0]          q_head;
   logic [7:0]             h_gray;
   logic [AW-1:0]          h_addr;
   rabs_pkg::rabs_tag_type h_tag;

   // Settings register writes
   always_comb begin
      alpha_in  = alpha_ff;
      thresh_in = thresh_ff;
      if (csr_write) begin
         case (rabs_pkg::rabs_csr_type'(csr_index))
            rabs_pkg::CSR_ALPHA_Q8: begin
               alpha_in = csr_wdata[rabs_pkg::ALPHA_W-1:0];
            end
            rabs_pkg::CSR_NOISE_THRESHOLD: begin
               thresh_in = csr_wdata[rabs_pkg::THRESH_W-1:0];
            end
            default: begin
               alpha_in  = alpha_ff;
               thresh_in = thresh_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= rabs_pkg::ALPHA_RESET;
         thresh_ff <= rabs_pkg::THRESH_RESET;
      end else begin
         alpha_ff  <= alpha_in;
         thresh_ff <= thresh_in;
      end
   end

   rabs_front #(
      .MAX_PIXELS (MAX_PIXELS),
      .AW         (AW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_blue      (req_blue),
      .req_green     (req_green),
      .req_red       (req_red),
      .req_frame_end (req_frame_end),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_gray        (f_gray),
      .q_addr        (f_addr),
      .q_tag         (f_tag)
   );

   rabs_queue #(
      .W     (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_gray, f_addr, f_tag}),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   // Unpack queue head
   assign h_gray = q_head[QW-1 -: 8];
   assign h_addr = q_head[TAG_W +: AW];
   assign h_tag  = rabs_pkg::rabs_tag_type'(q_head[TAG_W-1:0]);

   rabs_back #(
      .MAX_PIXELS (MAX_PIXELS),
      .AW         (AW)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_empty              (q_empty),
      .q_gray               (h_gray),
      .q_addr               (h_addr),
      .q_tag                (h_tag),
      .q_pop                (q_pop),
      .alpha_q8             (alpha_ff),
      .noise_threshold      (thresh_ff),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_foreground       (rsp_foreground),
      .rsp_background_level (rsp_background_level),
      .rsp_frame_last       (rsp_frame_last)
   );

endmodule

`default_nettype wire
